// ===== rtl/ial_pkg.sv =====
package ial_pkg;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FPOS_W   = 6;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 56;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Register index as decoded from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_GET    = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_ERASE  = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GET_WAIT,
    S_INSERT,
    S_ERASE,
    S_SEARCH,
    S_RESP
  } state_e;

endpackage

// ===== rtl/indexed_array_list_core.sv =====
// A get reads the element at its position; a refused get, insert or erase goes straight to
// the result; insert shifts the elements from position to the tail up, erase shifts those after it down;
// search walks from position 0 and stops at the first match or at the end of the list.
// One beat at a time, walking the memory with one read and one write per cycle;
// a new beat is taken while a result still waits.
// Reset is asynchronous and active low: the list is emptied and capacity_limit is 64.
module indexed_array_list_core #(
  parameter int DEPTH         = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // position [6:0], value [38:7], zero [39]
  input  logic [ial_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // action [1:0]
  input  logic [ial_pkg::ACTION_W-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status [1:0], read_value [33:2], found [34], found_position [40:35],
  // entry_count [47:41], is_empty [48], zero [55:49]
  output logic [ial_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ial_pkg::PADDR_W-1:0]    paddr,
  input  logic [ial_pkg::PDATA_W-1:0]    pwdata,
  output logic [ial_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import ial_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [XW-1:0] DepthX = XW'(DEPTH);

  logic [ELEMENT_WIDTH-1:0] mem_q [DEPTH];
  logic [ELEMENT_WIDTH-1:0] rdata_q;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;

  state_e                   state_q, state_d;
  action_e                  op_q;
  logic [POS_W-1:0]         pos_q;
  logic [VALUE_W-1:0]       val_q;
  status_e                  status_q, status_d;
  logic [XW-1:0]            ptr_q, ptr_d;
  logic                     pend_q, pend_d;
  logic [XW-1:0]            pend_idx_q, pend_idx_d;
  logic                     found_q, found_d;
  logic [FPOS_W-1:0]        fpos_q, fpos_d;
  logic [CW-1:0]            used_q, used_d;
  logic [CAP_W-1:0]         cap_q;
  logic                     m_valid_q, m_valid_d;
  logic [M_DATA_W-1:0]      m_data_q, m_data_d;

  logic                     s_hs, cfg_wr, out_free;
  logic [XW-1:0]            pos_x, used_x, cap_x, eff_cap;
  logic                     pos_lt_used, pos_gt_used, is_full;
  logic                     ptr_gt_pos, ptr_lt_used, hit;
  logic [ELEMENT_WIDTH-1:0] key;
  logic [VALUE_W-1:0]       read_value;
  logic [COUNT_W-1:0]       count_out;

  assign s_hs        = s_axis_tvalid && s_axis_tready;
  assign cfg_wr      = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign out_free    = !m_valid_q || m_axis_tready;
  assign pos_x       = XW'(pos_q);
  assign used_x      = XW'(used_q);
  assign cap_x       = XW'(cap_q);
  assign eff_cap     = (cap_x > DepthX) ? DepthX : cap_x;
  assign pos_lt_used = pos_x < used_x;
  assign pos_gt_used = pos_x > used_x;
  assign is_full     = used_x >= eff_cap;
  assign ptr_gt_pos  = ptr_q > pos_x;
  assign ptr_lt_used = ptr_q < used_x;
  assign key         = ELEMENT_WIDTH'(val_q);
  assign hit         = pend_q && (rdata_q == key);
  assign read_value  = (op_q == ACT_GET && status_q == ST_OK) ? VALUE_W'(rdata_q) : '0;
  assign count_out   = used_x[COUNT_W-1:0];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_hs) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (op_q)
          ACT_GET:    state_d = pos_lt_used ? S_GET_WAIT : S_RESP;
          ACT_INSERT: state_d = (pos_gt_used || is_full) ? S_RESP : S_INSERT;
          ACT_ERASE:  state_d = pos_lt_used ? S_ERASE : S_RESP;
          ACT_SEARCH: state_d = S_SEARCH;
          default:    state_d = S_RESP;
        endcase
      end
      S_GET_WAIT: state_d = S_RESP;
      S_INSERT: begin
        if (!ptr_gt_pos && !pend_q) state_d = S_RESP;
      end
      S_ERASE: begin
        if (!ptr_lt_used && !pend_q) state_d = S_RESP;
      end
      S_SEARCH: begin
        if (hit || (!ptr_lt_used && !pend_q)) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = pend_idx_q[AW-1:0];
    mem_raddr  = ptr_q[AW-1:0];
    mem_wdata  = rdata_q;
    status_d   = status_q;
    ptr_d      = ptr_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    found_d    = found_q;
    fpos_d     = fpos_q;
    used_d     = used_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;

    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: ;
      S_DECODE: begin
        status_d = ST_OK;
        pend_d   = 1'b0;
        found_d  = 1'b0;
        fpos_d   = '0;
        unique case (op_q)
          ACT_GET: begin
            if (pos_lt_used) begin
              mem_re    = 1'b1;
              mem_raddr = pos_x[AW-1:0];
            end else begin
              status_d = ST_RANGE;
            end
          end
          ACT_INSERT: begin
            ptr_d = used_x;
            if (pos_gt_used) begin
              status_d = ST_RANGE;
            end else if (is_full) begin
              status_d = ST_FULL;
            end
          end
          ACT_ERASE: begin
            ptr_d = pos_x + 1'b1;
            if (!pos_lt_used) status_d = ST_RANGE;
          end
          ACT_SEARCH: ptr_d = '0;
          default: ;
        endcase
      end
      S_GET_WAIT: ;
      S_INSERT: begin
        if (pend_q) mem_we = 1'b1;
        if (ptr_gt_pos) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(ptr_q - 1'b1);
          pend_d     = 1'b1;
          pend_idx_d = ptr_q;
          ptr_d      = ptr_q - 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            mem_we    = 1'b1;
            mem_waddr = pos_x[AW-1:0];
            mem_wdata = key;
            used_d    = used_q + 1'b1;
          end
        end
      end
      S_ERASE: begin
        if (pend_q) mem_we = 1'b1;
        if (ptr_lt_used) begin
          mem_re     = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = ptr_q - 1'b1;
          ptr_d      = ptr_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) used_d = used_q - 1'b1;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          found_d = 1'b1;
          fpos_d  = pend_idx_q[FPOS_W-1:0];
          pend_d  = 1'b0;
        end else if (ptr_lt_used) begin
          mem_re     = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = ptr_q;
          ptr_d      = ptr_q + 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      S_RESP: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {7'b0, (used_q == '0), count_out, fpos_q, found_q,
                       read_value, status_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      cap_q     <= CAP_RESET;
      m_valid_q <= 1'b0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      m_valid_q <= m_valid_d;
      pend_q    <= pend_d;
      if (cfg_wr) cap_q <= pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      op_q  <= action_e'(s_axis_tuser);
      pos_q <= s_axis_tdata[POS_W-1:0];
      val_q <= s_axis_tdata[POS_W +: VALUE_W];
    end
    status_q   <= status_d;
    ptr_q      <= ptr_d;
    pend_idx_q <= pend_idx_d;
    found_q    <= found_d;
    fpos_q     <= fpos_d;
    m_data_q   <= m_data_d;
  end

endmodule

// ===== rtl/ial_checker.sv =====
module ial_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [ial_pkg::M_DATA_W-1:0] m_axis_tdata
);
  import ial_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while the previous beat is still at work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] <= ST_FULL)
    else $error("undefined status code");

  a_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[34] |->
      m_axis_tdata[1:0] == ST_OK && m_axis_tdata[33:2] == '0)
    else $error("search hit with a status or a read value");

endmodule

bind indexed_array_list_core ial_checker u_ial_checker (.*);
